>>> rtl/core/usri_pkg.sv
package usri_pkg;

	localparam int Q_W     = 32;
	localparam int PROD_W  = 2 * Q_W;
	localparam int RAD_W   = PROD_W;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int FRAC_W  = 16;
	localparam int DVD_W   = 49;
	localparam int DVS_W   = Q_W - 1;
	localparam int IN_W    = 9 * Q_W;
	localparam int OUT_W   = 4 * Q_W;

	// 1.0 in Q32.32, negated
	localparam logic signed [PROD_W-1:0] NEG_ONE_Q32 = 64'shFFFF_FFFF_0000_0000;

	// ray data that rides along the whole pipeline, start x in the lowest bits
	typedef struct packed {
		logic [Q_W-1:0]      best;
		logic [Q_W-1:0]      t_high;
		logic [Q_W-1:0]      t_low;
		logic [2:0][Q_W-1:0] d;
		logic [2:0][Q_W-1:0] s;
	} side_t;

	// sideband through the square root pipe
	typedef struct packed {
		logic                  miss;
		logic signed [Q_W-1:0] a;
		logic signed [Q_W-1:0] b;
		side_t                 side;
	} sq_side_t;

	// sideband through the divider pipe
	typedef struct packed {
		logic  miss;
		logic  neg0;
		logic  neg1;
		side_t side;
	} dv_side_t;

	// partial result of the digit-by-digit square root
	typedef struct packed {
		logic [ROOT_W+2:0]  rem;
		logic [ROOT_W-1:0]  root;
	} sq_acc_t;

	// result word
	typedef struct packed {
		logic [Q_W-1:0] nz;
		logic [Q_W-1:0] ny;
		logic [Q_W-1:0] nx;
		logic [Q_W-1:0] hit_t;
	} out_t;

	function automatic logic signed [PROD_W-1:0] sat_add64(
		input logic signed [PROD_W-1:0] x,
		input logic signed [PROD_W-1:0] y
	);
		logic signed [PROD_W:0] sum;
		sum = {x[PROD_W-1], x} + {y[PROD_W-1], y};
		if (sum[PROD_W] != sum[PROD_W-1]) begin
			if (sum[PROD_W])
				return {1'b1, {(PROD_W-1){1'b0}}};
			else
				return {1'b0, {(PROD_W-1){1'b1}}};
		end
		return sum[PROD_W-1:0];
	endfunction

	function automatic logic signed [Q_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
		if (x[PROD_W-1:Q_W-1] == {(PROD_W-Q_W+1){x[PROD_W-1]}})
			return x[Q_W-1:0];
		else if (x[PROD_W-1])
			return {1'b1, {(Q_W-1){1'b0}}};
		else
			return {1'b0, {(Q_W-1){1'b1}}};
	endfunction

	// one root bit: bring down two radicand bits, trial subtract
	function automatic sq_acc_t sqrt_step(input sq_acc_t acc, input logic [1:0] pair);
		sq_acc_t            r;
		logic [ROOT_W+2:0]  sh;
		logic [ROOT_W+2:0]  trial;
		sh    = {acc.rem[ROOT_W:0], pair};
		trial = {1'b0, acc.root, 2'b01};
		if (sh >= trial) begin
			r.rem  = sh - trial;
			r.root = {acc.root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem  = sh;
			r.root = {acc.root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	// one quotient bit of restoring division: {qbit, remainder}
	function automatic logic [DVS_W:0] div_step(
		input logic [DVS_W-1:0] rem,
		input logic             nb,
		input logic [DVS_W-1:0] dvs
	);
		logic [DVS_W:0] sh;
		sh = {rem, nb};
		if (sh >= {1'b0, dvs})
			return {1'b1, DVS_W'(sh - {1'b0, dvs})};
		return {1'b0, sh[DVS_W-1:0]};
	endfunction

	// signed quotient from magnitude, saturated to Q16.16
	function automatic logic signed [Q_W-1:0] quo_sat(input logic [DVD_W-1:0] q, input logic neg);
		if (neg) begin
			if (q > DVD_W'(64'h8000_0000))
				return {1'b1, {(Q_W-1){1'b0}}};
			return ~q[Q_W-1:0] + 32'd1;
		end
		if (q > DVD_W'(64'h7FFF_FFFF))
			return {1'b0, {(Q_W-1){1'b1}}};
		return q[Q_W-1:0];
	endfunction

endpackage

>>> rtl/core/usri_sqrt.sv
module usri_sqrt #(
	parameter int SIDE_W = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [usri_pkg::RAD_W-1:0]   radicand,
	input  logic [SIDE_W-1:0]            in_side,
	output logic                         out_valid,
	output logic [usri_pkg::ROOT_W-1:0]  root,
	output logic [SIDE_W-1:0]            out_side
);
	import usri_pkg::*;

	localparam int STEPS = ROOT_W;

	logic              v_s    [STEPS];
	logic [RAD_W-1:0]  rad_s  [STEPS];
	sq_acc_t           acc_s  [STEPS];
	logic [SIDE_W-1:0] side_s [STEPS];
	sq_acc_t           acc_nx [STEPS];

	// one root bit per stage, top radicand pair first
	always_comb begin
		acc_nx[0] = sqrt_step('0, radicand[RAD_W-1:RAD_W-2]);
		for (int k = 1; k < STEPS; k++)
			acc_nx[k] = sqrt_step(acc_s[k-1], rad_s[k-1][RAD_W-1:RAD_W-2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STEPS; k++)
				v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int k = 1; k < STEPS; k++)
				v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s[0]  <= radicand << 2;
			acc_s[0]  <= acc_nx[0];
			side_s[0] <= in_side;
			for (int k = 1; k < STEPS; k++) begin
				rad_s[k]  <= rad_s[k-1] << 2;
				acc_s[k]  <= acc_nx[k];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = v_s[STEPS-1];
	assign root      = acc_s[STEPS-1].root;
	assign out_side  = side_s[STEPS-1];

endmodule

>>> rtl/core/usri_div.sv
module usri_div #(
	parameter int SIDE_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [usri_pkg::DVD_W-1:0]  dvd [2],
	input  logic [usri_pkg::DVS_W-1:0]  dvs,
	input  logic [SIDE_W-1:0]           in_side,
	output logic                        out_valid,
	output logic [usri_pkg::DVD_W-1:0]  quo [2],
	output logic [SIDE_W-1:0]           out_side
);
	import usri_pkg::*;

	localparam int STEPS = DVD_W;

	logic              v_s    [STEPS];
	logic [DVD_W-1:0]  dvd_s  [STEPS][2];
	logic [DVD_W-1:0]  quo_s  [STEPS][2];
	logic [DVS_W-1:0]  rem_s  [STEPS][2];
	logic [DVS_W-1:0]  dvs_s  [STEPS];
	logic [SIDE_W-1:0] side_s [STEPS];
	logic [DVS_W:0]    rq_nx  [STEPS][2];

	// one quotient bit per stage and lane, dividend msb first
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			rq_nx[0][l] = div_step('0, dvd[l][DVD_W-1], dvs);
			for (int k = 1; k < STEPS; k++)
				rq_nx[k][l] = div_step(rem_s[k-1][l], dvd_s[k-1][l][DVD_W-1], dvs_s[k-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STEPS; k++)
				v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int k = 1; k < STEPS; k++)
				v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvs_s[0]  <= dvs;
			side_s[0] <= in_side;
			for (int l = 0; l < 2; l++) begin
				dvd_s[0][l] <= dvd[l] << 1;
				rem_s[0][l] <= rq_nx[0][l][DVS_W-1:0];
				quo_s[0][l] <= {{(DVD_W-1){1'b0}}, rq_nx[0][l][DVS_W]};
			end
			for (int k = 1; k < STEPS; k++) begin
				dvs_s[k]  <= dvs_s[k-1];
				side_s[k] <= side_s[k-1];
				for (int l = 0; l < 2; l++) begin
					dvd_s[k][l] <= dvd_s[k-1][l] << 1;
					rem_s[k][l] <= rq_nx[k][l][DVS_W-1:0];
					quo_s[k][l] <= {quo_s[k-1][l][DVD_W-2:0], rq_nx[k][l][DVS_W]};
				end
			end
		end
	end

	assign out_valid = v_s[STEPS-1];
	assign quo[0]    = quo_s[STEPS-1][0];
	assign quo[1]    = quo_s[STEPS-1][1];
	assign out_side  = side_s[STEPS-1];

endmodule

>>> rtl/core/unit_sphere_ray_intersect_top.sv
// Ray test against the unit sphere at the origin, fully pipelined.
// Input channel s_*: one ray per transfer, nine signed Q16.16 fields packed in
// s_tdata (start x/y/z, dir x/y/z, t_low, t_high, best_t from the lowest bit).
// Output channel m_*: one result per ray, in order. m_tuser is the hit flag,
// m_tdata holds hit_t and the normal x/y/z (zero on a miss).
// The path from the input transfer to m_tvalid runs through five stages of
// products, sums, scaling and discriminant, 32 stages of square root (one root
// bit each), one numerator stage, 49 stages of the two parallel dividers (one
// quotient bit each) and four stages for root sign and saturation, root select,
// normal product, and normal sum with output register.
// Throughput is one ray per cycle while m_tready stays high.
// When the receiver stalls, the result in the output register moves into a
// skid register and the pipeline freezes in the following cycle; s_tready is the
// registered inverse of the skid being full, so nothing is lost or repeated.
// Reset clears all valid bits and the skid; data registers are not reset.
module unit_sphere_ray_intersect_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// start_x, start_y, start_z, dir_x, dir_y, dir_z, t_low, t_high, best_t
	input  logic [usri_pkg::IN_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// hit_t, normal_x, normal_y, normal_z
	output logic [usri_pkg::OUT_W-1:0] m_tdata,
	// hit
	output logic                       m_tuser
);
	import usri_pkg::*;

	logic  en;
	logic  skid_q;
	side_t side_in;

	assign en       = !skid_q;
	assign s_tready = en;
	assign side_in  = side_t'(s_tdata);

	// valid bits of the top-level stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic v_sq, v_dv;

	// s1: exact Q32.32 products
	logic signed [PROD_W-1:0] pdd_s1 [3];
	logic signed [PROD_W-1:0] pds_s1 [3];
	logic signed [PROD_W-1:0] pss_s1 [3];
	side_t                    side_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pdd_s1[i] <= $signed(side_in.d[i]) * $signed(side_in.d[i]);
				pds_s1[i] <= $signed(side_in.d[i]) * $signed(side_in.s[i]);
				pss_s1[i] <= $signed(side_in.s[i]) * $signed(side_in.s[i]);
			end
			side_s1 <= side_in;
		end
	end

	// s2: saturating dot products
	logic signed [PROD_W-1:0] dd_s2, ds_s2, ss_s2;
	side_t                    side_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			dd_s2   <= sat_add64(sat_add64(pdd_s1[0], pdd_s1[1]), pdd_s1[2]);
			ds_s2   <= sat_add64(sat_add64(pds_s1[0], pds_s1[1]), pds_s1[2]);
			ss_s2   <= sat_add64(sat_add64(pss_s1[0], pss_s1[1]), pss_s1[2]);
			side_s2 <= side_s1;
		end
	end

	// s3: back to Q16.16, floor and saturate
	logic signed [Q_W-1:0] a_s3, b_s3, c_s3;
	side_t                 side_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3    <= sat32(dd_s2 >>> FRAC_W);
			b_s3    <= sat32(ds_s2 >>> FRAC_W);
			c_s3    <= sat32(sat_add64(ss_s2, NEG_ONE_Q32) >>> FRAC_W);
			side_s3 <= side_s2;
		end
	end

	// s4: discriminant products
	logic signed [PROD_W-1:0] bb_s4, ac_s4;
	logic signed [Q_W-1:0]    a_s4, b_s4;
	logic                     azero_s4;
	side_t                    side_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			bb_s4    <= b_s3 * b_s3;
			ac_s4    <= a_s3 * c_s3;
			a_s4     <= a_s3;
			b_s4     <= b_s3;
			azero_s4 <= (a_s3 == '0);
			side_s4  <= side_s3;
		end
	end

	// s5: discriminant and early miss
	logic [PROD_W-1:0] disc;
	logic [RAD_W-1:0]  rad_s5;
	sq_side_t          sqs_s5;

	assign disc = bb_s4 - ac_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s5      <= disc[PROD_W-1] ? '0 : disc;
			sqs_s5.miss <= azero_s4 | disc[PROD_W-1];
			sqs_s5.a    <= a_s4;
			sqs_s5.b    <= b_s4;
			sqs_s5.side <= side_s4;
		end
	end

	// square root pipe
	logic [ROOT_W-1:0]          root_sq;
	logic [$bits(sq_side_t)-1:0] sq_vec;
	sq_side_t                   sq_out;

	usri_sqrt #(
		.SIDE_W($bits(sq_side_t))
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s5),
		.radicand (rad_s5),
		.in_side  (sqs_s5),
		.out_valid(v_sq),
		.root     (root_sq),
		.out_side (sq_vec)
	);

	assign sq_out = sq_side_t'(sq_vec);

	// s6: numerators -b -/+ r as sign and magnitude
	logic [Q_W+1:0]   nb, n0, n1;
	logic [Q_W:0]     mag0, mag1;
	logic [DVD_W-1:0] dvd_s6 [2];
	logic [DVS_W-1:0] dvs_s6;
	dv_side_t         dvs_side_s6;

	always_comb begin
		nb   = ~{{2{sq_out.b[Q_W-1]}}, sq_out.b} + 34'd1;
		n0   = nb - {2'b00, root_sq};
		n1   = nb + {2'b00, root_sq};
		mag0 = n0[Q_W+1] ? (~n0[Q_W:0] + 33'd1) : n0[Q_W:0];
		mag1 = n1[Q_W+1] ? (~n1[Q_W:0] + 33'd1) : n1[Q_W:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_s6[0]        <= {mag0, {FRAC_W{1'b0}}};
			dvd_s6[1]        <= {mag1, {FRAC_W{1'b0}}};
			dvs_s6           <= sq_out.a[DVS_W-1:0];
			dvs_side_s6.miss <= sq_out.miss;
			dvs_side_s6.neg0 <= n0[Q_W+1];
			dvs_side_s6.neg1 <= n1[Q_W+1];
			dvs_side_s6.side <= sq_out.side;
		end
	end

	// divider pipe, both roots in parallel
	logic [DVD_W-1:0]            quo_dv [2];
	logic [$bits(dv_side_t)-1:0] dv_vec;
	dv_side_t                    dv_out;

	usri_div #(
		.SIDE_W($bits(dv_side_t))
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s6),
		.dvd      (dvd_s6),
		.dvs      (dvs_s6),
		.in_side  (dvs_side_s6),
		.out_valid(v_dv),
		.quo      (quo_dv),
		.out_side (dv_vec)
	);

	assign dv_out = dv_side_t'(dv_vec);

	// s7: signed, saturated roots
	logic signed [Q_W-1:0] t0_s7, t1_s7;
	logic                  miss_s7;
	side_t                 side_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			t0_s7   <= quo_sat(quo_dv[0], dv_out.neg0);
			t1_s7   <= quo_sat(quo_dv[1], dv_out.neg1);
			miss_s7 <= dv_out.miss;
			side_s7 <= dv_out.side;
		end
	end

	// s8: pick the root in the interval, compare with best
	logic                  in0, in1;
	logic signed [Q_W-1:0] t_pick;
	logic                  hit_s8;
	logic signed [Q_W-1:0] t_s8;
	side_t                 side_s8;

	always_comb begin
		in0    = (t0_s7 >= $signed(side_s7.t_low)) && (t0_s7 <= $signed(side_s7.t_high));
		in1    = (t1_s7 >= $signed(side_s7.t_low)) && (t1_s7 <= $signed(side_s7.t_high));
		t_pick = in0 ? t0_s7 : t1_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s8  <= !miss_s7 && (in0 || in1) && (t_pick < $signed(side_s7.best));
			t_s8    <= t_pick;
			side_s8 <= side_s7;
		end
	end

	// s9: t * dir
	logic signed [PROD_W-1:0] ptd_s9 [3];
	logic                     hit_s9;
	logic signed [Q_W-1:0]    t_s9;
	side_t                    side_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				ptd_s9[i] <= t_s8 * $signed(side_s8.d[i]);
			hit_s9  <= hit_s8;
			t_s9    <= t_s8;
			side_s9 <= side_s8;
		end
	end

	// s10: normals and result register
	out_t out_s10;
	logic hit_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s10       <= hit_s9;
			out_s10.hit_t <= hit_s9 ? t_s9 : side_s9.best;
			out_s10.nx    <= hit_s9 ? sat32((ptd_s9[0] >>> FRAC_W)
				+ PROD_W'($signed(side_s9.s[0]))) : '0;
			out_s10.ny    <= hit_s9 ? sat32((ptd_s9[1] >>> FRAC_W)
				+ PROD_W'($signed(side_s9.s[1]))) : '0;
			out_s10.nz    <= hit_s9 ? sat32((ptd_s9[2] >>> FRAC_W)
				+ PROD_W'($signed(side_s9.s[2]))) : '0;
		end
	end

	// valid chain of the top-level stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s1  <= s_tvalid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_sq;
			v_s7  <= v_dv;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// skid register: catches the result when the receiver stalls
	out_t skid_data_q;
	logic skid_hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			skid_q <= 1'b0;
		else if (!skid_q)
			skid_q <= v_s10 && !m_tready;
		else if (m_tready)
			skid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (en && v_s10 && !m_tready) begin
			skid_data_q <= out_s10;
			skid_hit_q  <= hit_s10;
		end
	end

	assign m_tvalid = skid_q | v_s10;
	assign m_tdata  = skid_q ? skid_data_q : out_s10;
	assign m_tuser  = skid_q ? skid_hit_q : hit_s10;

endmodule
